[design/address_range_allocator_coalescing_unit_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the range allocator
// Shared property wrappers used at the end of the top design module.
// ----------------------------------------------------------------------------
`ifndef ADDRESS_RANGE_ALLOCATOR_COALESCING_UNIT_DEFINES_SVH
`define ADDRESS_RANGE_ALLOCATOR_COALESCING_UNIT_DEFINES_SVH

// implication checked on every edge outside reset
`define ARA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication checked outside reset
`define ARA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/arac_pkg.sv]
// ----------------------------------------------------------------------------
// arac_pkg
// Types and constants for the range allocator.
// ----------------------------------------------------------------------------
package arac_pkg;
    localparam int unsigned TableDepthDef = 1024;
    localparam int unsigned PageBytesDef  = 4096;
    localparam logic [63:0] BaseAtReset   = 64'hFFFF_FFFF_8800_0000;
    localparam logic [63:0] EndAtReset    = 64'hFFFF_FFFF_9000_0000;
    localparam logic [15:0] PagesMax      = 16'hFFFF;

    localparam logic CmdAlloc = 1'b0;
    localparam logic CmdFree  = 1'b1;

    localparam logic [2:0] StTable   = 3'd0;
    localparam logic [2:0] StBump    = 3'd1;
    localparam logic [2:0] StNoSpace = 3'd2;
    localparam logic [2:0] StMerged  = 3'd3;
    localparam logic [2:0] StAppend  = 3'd4;
    localparam logic [2:0] StDropped = 3'd5;

    localparam logic RegBase = 1'b0;
    localparam logic RegEnd  = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD,      // issue read of entry r_idx
        S_WAIT,    // memory latency
        S_CHK,     // examine entry
        S_MRD,     // merge scan read
        S_MWAIT,
        S_MCHK,
        S_LRD,     // read last entry
        S_LWAIT,
        S_LMOVE,   // write last into hole
        S_BUMP,
        S_OUT
    } t_state;

    // memory write request
    typedef struct packed {
        logic        we;
        logic [11:0] addr;
        logic [63:0] start;
        logic [15:0] pages;
    } t_mem_wr;

    function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        sat_add = s[16] ? PagesMax : s[15:0];
    endfunction
endpackage

[design/arac_table.sv]
// ----------------------------------------------------------------------------
// arac_table
// Free range table: one write port, one registered read port.
// ----------------------------------------------------------------------------
module arac_table #(
    parameter int unsigned TABLE_DEPTH = arac_pkg::TableDepthDef,
    localparam int unsigned Aw = $clog2(TABLE_DEPTH)
) (
    input  logic            i_clk,
    input  arac_pkg::t_mem_wr i_wr,
    input  logic [Aw-1:0]   i_raddr,
    output logic [63:0]     o_rstart,
    output logic [15:0]     o_rpages
);
    import arac_pkg::*;

    logic [63:0] r_start [TABLE_DEPTH];
    logic [15:0] r_pages [TABLE_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_start[i_wr.addr[Aw-1:0]] <= i_wr.start;
            r_pages[i_wr.addr[Aw-1:0]] <= i_wr.pages;
        end
        o_rstart <= r_start[i_raddr];
        o_rpages <= r_pages[i_raddr];
    end
endmodule

[design/address_range_allocator_coalescing_unit.sv]
// ----------------------------------------------------------------------------
// address_range_allocator_coalescing_unit
// First-fit free range allocator with bump-pointer fallback and merge on free.
//
//  channel | direction | signals
//  req     | in        | i_valid/o_ready, i_cmd, i_range_start, i_page_count
//  rsp     | out       | o_valid/i_ready, o_granted_address, o_status
//  cfg     | in        | i_cfg_we, i_cfg_idx, i_cfg_wdata
//
// A transaction reads one table entry at a time through the single read port
// (S_RD, S_WAIT, S_CHK); a free with merge can scan the table a second time.
// Reset is synchronous; the table needs no clearing (entry count only).
// A stalled response holds the block; the next request waits until taken.
// ----------------------------------------------------------------------------
`include "address_range_allocator_coalescing_unit_defines.svh"

module address_range_allocator_coalescing_unit #(
    parameter int unsigned TABLE_DEPTH = arac_pkg::TableDepthDef,
    parameter int unsigned PAGE_BYTES  = arac_pkg::PageBytesDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_cmd,
    input  logic [63:0] i_range_start,
    input  logic [15:0] i_page_count,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_granted_address,
    output logic [2:0]  o_status,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [63:0] i_cfg_wdata
);
    import arac_pkg::*;

    localparam int unsigned Aw = $clog2(TABLE_DEPTH);
    localparam int unsigned Cw = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned Sh = $clog2(PAGE_BYTES);

    t_state r_state, n_state;
    logic [63:0] r_end, r_bump, n_bump;
    logic [Cw-1:0] r_cnt, n_cnt, r_idx, n_idx, r_hit, n_hit;
    logic        r_cmd;
    logic [63:0] r_start, n_start2;
    logic [15:0] r_pg;
    logic [63:0] r_addr, n_addr;
    logic [2:0]  r_st, n_st;
    logic [63:0] r_hs, n_hs;   // held entry start
    logic [15:0] r_hp, n_hp;   // held entry pages
    logic [Cw-1:0] r_hole, n_hole;
    t_mem_wr     w_wr;
    logic [Aw-1:0] w_raddr;
    logic [63:0] w_rs;
    logic [15:0] w_rp;
    logic [63:0] w_len, w_elen, w_rend, w_next, w_top;
    logic        w_carry;

    assign w_len  = 64'(r_pg) << Sh;
    assign w_elen = 64'(w_rp) << Sh;
    assign w_rend = w_rs + w_elen;
    assign {w_carry, w_next} = {1'b0, r_bump} + {1'b0, w_len};
    assign w_top  = r_hs + (64'(r_hp) << Sh);

    arac_table #(.TABLE_DEPTH(TABLE_DEPTH)) u_table (
        .i_clk(i_clk), .i_wr(w_wr), .i_raddr(w_raddr),
        .o_rstart(w_rs), .o_rpages(w_rp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_end   <= EndAtReset;
            r_bump  <= BaseAtReset;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (i_cfg_we && i_cfg_idx == RegBase) begin
                r_bump <= i_cfg_wdata;
            end else begin
                r_bump <= n_bump;
            end
            if (i_cfg_we && i_cfg_idx == RegEnd) begin
                r_end <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_cmd   <= i_cmd;
            r_start <= i_range_start;
            r_pg    <= i_page_count;
        end else begin
            r_start <= n_start2;
        end
        r_idx  <= n_idx;
        r_hit  <= n_hit;
        r_addr <= n_addr;
        r_st   <= n_st;
        r_hs   <= n_hs;
        r_hp   <= n_hp;
        r_hole <= n_hole;
    end

    assign w_raddr = (r_state == S_LRD || r_state == S_LWAIT) ? Aw'(r_cnt - 1'b1) : Aw'(r_idx);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_valid) n_state = S_RD;
            S_RD: begin
                if (r_pg == '0) n_state = S_OUT;
                else if (r_idx >= r_cnt) n_state = (r_cmd == CmdAlloc) ? S_BUMP : S_OUT;
                else n_state = S_WAIT;
            end
            S_WAIT: n_state = S_CHK;
            S_CHK: begin
                if (r_cmd == CmdAlloc) begin
                    if (w_rp >= r_pg) n_state = (w_rp == r_pg) ? S_LRD : S_OUT;
                    else n_state = S_RD;
                end else begin
                    if (w_rend == r_start) n_state = S_MRD;
                    else if (r_start + w_len == w_rs) n_state = S_OUT;
                    else n_state = S_RD;
                end
            end
            S_MRD:   n_state = (r_idx >= r_cnt) ? S_OUT : S_MWAIT;
            S_MWAIT: n_state = S_MCHK;
            S_MCHK: begin
                if (r_idx != r_hit && w_rs == w_top) n_state = S_LRD;
                else n_state = S_MRD;
            end
            S_LRD:   n_state = S_LWAIT;
            S_LWAIT: n_state = S_LMOVE;
            S_LMOVE: n_state = S_OUT;
            S_BUMP:  n_state = S_OUT;
            S_OUT:   if (i_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_idx = r_idx; n_hit = r_hit; n_addr = r_addr; n_st = r_st;
        n_hs = r_hs; n_hp = r_hp; n_hole = r_hole; n_cnt = r_cnt;
        n_bump = r_bump; n_start2 = r_start;
        w_wr = '0;
        unique case (r_state)
            S_IDLE: begin
                n_idx = '0; n_addr = '0;
                n_st = i_cmd ? StDropped : StNoSpace;
            end
            S_RD: begin
                if (r_pg != '0 && r_idx >= r_cnt && r_cmd == CmdFree) begin
                    if (r_cnt < Cw'(TABLE_DEPTH)) begin
                        w_wr = '{we: 1'b1, addr: 12'(r_cnt), start: r_start, pages: r_pg};
                        n_cnt = r_cnt + 1'b1;
                        n_st = StAppend;
                    end
                end
            end
            S_CHK: begin
                if (r_cmd == CmdAlloc) begin
                    if (w_rp >= r_pg) begin
                        n_addr = w_rs; n_st = StTable;
                        if (w_rp == r_pg) begin
                            n_hole = r_idx;
                        end else begin
                            w_wr = '{we: 1'b1, addr: 12'(r_idx), start: w_rs + w_len,
                                     pages: w_rp - r_pg};
                        end
                    end else n_idx = r_idx + 1'b1;
                end else begin
                    n_st = StMerged;
                    if (w_rend == r_start) begin
                        n_hit = r_idx; n_hs = w_rs; n_hp = sat_add(w_rp, r_pg);
                        w_wr = '{we: 1'b1, addr: 12'(r_idx), start: w_rs,
                                 pages: sat_add(w_rp, r_pg)};
                        n_idx = '0;
                    end else if (r_start + w_len == w_rs) begin
                        w_wr = '{we: 1'b1, addr: 12'(r_idx), start: r_start,
                                 pages: sat_add(w_rp, r_pg)};
                    end else begin
                        n_st = StDropped;
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            S_MCHK: begin
                if (r_idx != r_hit && w_rs == w_top) begin
                    w_wr = '{we: 1'b1, addr: 12'(r_hit), start: r_hs,
                             pages: sat_add(r_hp, w_rp)};
                    n_hole = r_idx;
                end else n_idx = r_idx + 1'b1;
            end
            S_LMOVE: begin
                w_wr = '{we: 1'b1, addr: 12'(r_hole), start: w_rs, pages: w_rp};
                n_cnt = r_cnt - 1'b1;
            end
            S_BUMP: begin
                if (!w_carry && w_next <= r_end) begin
                    n_addr = r_bump; n_st = StBump; n_bump = w_next;
                end
            end
            default: ;
        endcase
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_granted_address = r_addr;
    assign o_status = r_st;

    `ARA_ASSERT_IMP(a_cnt_range, i_clk, i_rst_n, 1'b1, r_cnt <= Cw'(TABLE_DEPTH), "count over depth")
    `ARA_ASSERT_IMP(a_free_no_addr, i_clk, i_rst_n, o_valid && o_status >= StMerged, o_granted_address == '0, "free gave address")
    `ARA_ASSERT_NXT(a_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_status), "response dropped")
endmodule

[tb/sv/address_range_allocator_coalescing_unit_tb.sv]
// ----------------------------------------------------------------------------
// address_range_allocator_coalescing_unit_tb
// Self-checking bench for the range allocator. Allocate and free requests go
// in over valid/ready, and each response is checked against an in-bench model
// of the free-range table, the bump pointer and the region registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module address_range_allocator_coalescing_unit_tb;
    import arac_pkg::*;

    localparam int unsigned Depth     = 1024;
    localparam int unsigned PageBytes = 4096;
    localparam int unsigned StallLimit = 40000;

    typedef struct packed {
        logic [63:0] addr;
        logic [2:0]  status;
    } t_response;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_cmd = CmdAlloc;
    logic [63:0] i_range_start = '0;
    logic [15:0] i_page_count = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [63:0] o_granted_address;
    logic [2:0]  o_status;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = RegBase;
    logic [63:0] i_cfg_wdata = '0;

    address_range_allocator_coalescing_unit u_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // allocator shadow state
    logic [63:0] tbl_start [Depth];
    logic [15:0] tbl_pages [Depth];
    int unsigned tbl_count;
    logic [63:0] bump_ptr, base_reg, end_reg;

    t_response   pending_rsp[$];
    logic [63:0] live_start[$];
    logic [15:0] live_pages[$];
    bit          no_idle = 1'b0;
    int          errors = 0;
    int          n_req = 0, n_rsp = 0, stall_cycles = 0;
    int          n_stat[8];

    function automatic logic [15:0] pages_sum(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[16] ? 16'hFFFF : s[15:0];
    endfunction

    function automatic logic [63:0] span(input logic [15:0] p);
        return 64'(p) * PageBytes;
    endfunction

    function automatic void remove_entry(input int unsigned k);
        tbl_start[k] = tbl_start[tbl_count-1];
        tbl_pages[k] = tbl_pages[tbl_count-1];
        tbl_count--;
    endfunction

    function automatic t_response allocate_range(input logic [15:0] p);
        t_response   r;
        logic [64:0] nxt;
        r = '{addr: '0, status: StNoSpace};
        if (p == 0) return r;
        for (int unsigned i = 0; i < tbl_count; i++) begin
            if (tbl_pages[i] >= p) begin
                r = '{addr: tbl_start[i], status: StTable};
                if (tbl_pages[i] == p) begin
                    remove_entry(i);
                end else begin
                    tbl_start[i] += span(p);
                    tbl_pages[i] -= p;
                end
                return r;
            end
        end
        nxt = {1'b0, bump_ptr} + {1'b0, span(p)};
        if (nxt[64] || nxt[63:0] > end_reg) return r;
        r = '{addr: bump_ptr, status: StBump};
        bump_ptr = nxt[63:0];
        return r;
    endfunction

    function automatic logic [2:0] free_range(input logic [63:0] s, input logic [15:0] p);
        logic [63:0] fin, top;
        if (p == 0) return StDropped;
        fin = s + span(p);
        for (int unsigned i = 0; i < tbl_count; i++) begin
            if (tbl_start[i] + span(tbl_pages[i]) == s) begin
                tbl_pages[i] = pages_sum(tbl_pages[i], p);
                top = tbl_start[i] + span(tbl_pages[i]);
                for (int unsigned j = 0; j < tbl_count; j++) begin
                    if (j != i && tbl_start[j] == top) begin
                        tbl_pages[i] = pages_sum(tbl_pages[i], tbl_pages[j]);
                        remove_entry(j);
                        break;
                    end
                end
                return StMerged;
            end
            if (fin == tbl_start[i]) begin
                tbl_start[i] = s;
                tbl_pages[i] = pages_sum(tbl_pages[i], p);
                return StMerged;
            end
        end
        if (tbl_count >= Depth) return StDropped;
        tbl_start[tbl_count] = s;
        tbl_pages[tbl_count] = p;
        tbl_count++;
        return StAppend;
    endfunction

    task automatic send_request(input logic cmd, input logic [63:0] s, input logic [15:0] p,
                                output t_response r);
        int gap;
        gap = 0;
        while (!no_idle && $urandom_range(99) < 36) gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_cmd         <= cmd;
        i_range_start <= s;
        i_page_count  <= p;
        do @(posedge i_clk); while (!o_ready);
        r = (cmd == CmdAlloc) ? allocate_range(p)
                              : t_response'{addr: '0, status: free_range(s, p)};
        pending_rsp.push_back(r);
        n_req++;
        n_stat[r.status]++;
    endtask

    task automatic request_alloc(input logic [15:0] p);
        t_response r;
        send_request(CmdAlloc, 64'($urandom()), p, r);
        if (r.status == StTable || r.status == StBump) begin
            live_start.push_back(r.addr);
            live_pages.push_back(p);
        end
    endtask

    task automatic request_free(input logic [63:0] s, input logic [15:0] p);
        t_response r;
        send_request(CmdFree, s, p, r);
    endtask

    task automatic write_register(input logic idx, input logic [63:0] v);
        i_valid <= 1'b0;
        wait (pending_rsp.size() == 0);
        repeat (8) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == RegBase) begin
            base_reg = v;
            bump_ptr = v;
        end else begin
            end_reg = v;
        end
    endtask

    // response side: random back-pressure and in-order compare
    always @(posedge i_clk) begin
        i_ready <= no_idle || ($urandom_range(99) >= 36);
        if (i_rst_n && o_valid && i_ready) begin
            n_rsp++;
            if (pending_rsp.size() == 0) begin
                $error("unexpected transaction: addr %h status %0d", o_granted_address, o_status);
                errors++;
            end else begin
                t_response e;
                e = pending_rsp.pop_front();
                if (o_granted_address !== e.addr) begin
                    $error("granted_address: expected %h, got %h", e.addr, o_granted_address);
                    errors++;
                end
                if (o_status !== e.status) begin
                    $error("status: expected %0d, got %0d", e.status, o_status);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (i_rst_n && stall_cycles > StallLimit) begin
            $display("watchdog: no transaction for %0d cycles", StallLimit);
            $display("address_range_allocator_coalescing_unit_tb NOT OK");
            $finish;
        end
    end

    task automatic test_zero_pages();
        request_alloc(16'd0);
        request_free(64'h0000_0000_0010_0000, 16'd0);
    endtask

    task automatic test_merge_chain();
        logic [63:0] a;
        a = bump_ptr;
        request_alloc(16'd4);
        request_alloc(16'd4);
        request_alloc(16'd4);
        request_free(a, 16'd4);
        request_free(a + span(16'd8), 16'd4);
        request_free(a + span(16'd4), 16'd4);        // grows up, absorbs the third
        request_alloc(16'd12);                       // exact fit
        request_free(64'h0000_0040_0000_0000, 16'd8);
        request_free(64'h0000_0040_0000_0000 - span(16'd2), 16'd2); // extends downward
        request_alloc(16'd3);                        // split from front
        request_alloc(16'd7);                        // exact fit
        request_free(64'h0000_0050_0000_0123, 16'd1); // unaligned start
    endtask

    task automatic test_saturation();
        logic [63:0] s;
        s = 64'h0000_0060_0000_0000;
        request_free(s, 16'hFFFF);
        request_free(s + span(16'hFFFF), 16'd10);    // page count clips
        request_alloc(16'd40000);
        request_alloc(16'h8000);
    endtask

    task automatic test_bump_limits();
        write_register(RegEnd, bump_ptr + span(16'd2));
        request_alloc(16'd3);
        request_alloc(16'd2);
        write_register(RegBase, 64'hFFFF_FFFF_FFFF_F000);
        write_register(RegEnd, 64'hFFFF_FFFF_FFFF_FFFF);
        request_alloc(16'hFFFF);                     // carries out of 64 bits
        write_register(RegBase, 64'h0);
        write_register(RegEnd, 64'h0);
        request_alloc(16'hFFFF);
        write_register(RegEnd, 64'hFFFF_FFFF_FFFF_FFFF);
        request_alloc(16'hFFFF);
    endtask

    task automatic test_random_traffic(input int count);
        int unsigned k, sel;
        logic [15:0] p;
        write_register(RegBase, 64'h0000_0000_1000_0000);
        write_register(RegEnd, 64'h0000_0000_5000_0000);
        for (int n = 0; n < count; n++) begin
            no_idle = (n >= count / 2) && (n < count / 2 + 60);
            sel = $urandom_range(99);
            if (sel < 45 || live_start.size() == 0) begin
                p = ($urandom_range(19) == 0) ? 16'($urandom) : 16'($urandom_range(1, 24));
                request_alloc(p);
            end else if (sel < 85) begin
                k = $urandom_range(live_start.size() - 1);
                if (live_pages[k] > 1 && $urandom_range(3) == 0) begin
                    // return only the tail part
                    p = 16'($urandom_range(1, live_pages[k] - 1));
                    request_free(live_start[k] + span(p), live_pages[k] - p);
                end else begin
                    request_free(live_start[k], live_pages[k]);
                end
                live_start.delete(k);
                live_pages.delete(k);
            end else begin
                request_free({$urandom(), $urandom()}, 16'($urandom));
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin
        base_reg  = BaseAtReset;
        end_reg   = EndAtReset;
        bump_ptr  = BaseAtReset;
        tbl_count = 0;
        foreach (n_stat[i]) n_stat[i] = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_zero_pages();
        test_merge_chain();
        test_saturation();
        test_bump_limits();
        test_random_traffic(265);
        i_valid <= 1'b0;
        wait (pending_rsp.size() == 0);
        repeat (50) @(posedge i_clk);
        $display("requests %0d, responses %0d: table %0d, bump %0d, no space %0d",
                 n_req, n_rsp, n_stat[StTable], n_stat[StBump], n_stat[StNoSpace]);
        $display("merged %0d, appended %0d, dropped %0d; %0d entries left in the table",
                 n_stat[StMerged], n_stat[StAppend], n_stat[StDropped], tbl_count);
        if (errors == 0 && pending_rsp.size() == 0) begin
            $display("address_range_allocator_coalescing_unit_tb OK");
        end else begin
            $display("address_range_allocator_coalescing_unit_tb NOT OK");
        end
        $finish;
    end
endmodule
